FILE: sv/cdq_pkg.sv
// Shared types and constants for the circular deque with rank insert and remove.
package cdq_pkg;

    localparam int OP_W     = 3;
    localparam int RANK_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_AT  = 3'd0,
        OP_REMOVE_AT  = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_PUSH_BACK  = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_POP_BACK   = 3'd5,
        OP_READ_AT    = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANK  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TARGET,
        S_CAPTURE,
        S_SHIFT,
        S_STORE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic plan;
        logic read_target;
        logic capture;
        logic shift;
        logic store;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic plan_target;
        logic plan_store;
        logic rem;
        logic store;
        logic shift_busy;
        logic out_free;
    } sts_t;

endpackage

FILE: sv/cdq_req_if.sv
// Request channel of the circular deque.
interface cdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::OP_W-1:0]            operation;
    logic [cdq_pkg::RANK_W-1:0]          rank;
    logic signed [cdq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output operation, output rank, output value, input ready);
    modport sink (input valid, input operation, input rank, input value, output ready);
endinterface

FILE: sv/cdq_rsp_if.sv
// Result channel of the circular deque.
interface cdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [cdq_pkg::VALUE_W-1:0]  result_value;
    logic [cdq_pkg::STATUS_W-1:0]        status;
    logic [cdq_pkg::COUNT_W-1:0]         element_count;

    modport source (output valid, output result_value, output status, output element_count,
                    input ready);
    modport sink (input valid, input result_value, input status, input element_count,
                  output ready);
endinterface

FILE: sv/circular_deque_rank_insert_remove.sv
// Top level of the circular deque with rank insert and remove.
// One request is handled at a time and yields one result. A request passes through decode,
// then the target read and capture for read_at or a removal, then for an insert or removal
// a shift of n words (at most CAPACITY / 2, zero for pushes and pops), then the store for an
// insert, and finish; a failed or unused request goes from decode to finish. The ring memory,
// with one read and one write port, moves one word per cycle while shifting. A finished result
// sits in an output register while the next request waits for the block to return to idle.
module circular_deque_rank_insert_remove #(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input logic        clk,
    input logic        rst_n,
    cdq_req_if.sink    req,
    cdq_rsp_if.source  rsp
);
    import cdq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cdq_datapath #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (req.operation),
        .rank          (req.rank),
        .value         (req.value),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .result_value  (rsp.result_value),
        .status        (rsp.status),
        .element_count (rsp.element_count)
    );

endmodule

FILE: sv/cdq_ctrl.sv
// Controller state machine that sequences decode, target read, shifting, store and completion.
module cdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cdq_pkg::sts_t sts,
    output cdq_pkg::cmd_t cmd
);
    import cdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.plan_target)
                begin
                    state_next = S_TARGET;
                end
                else if (sts.plan_store)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_TARGET:
            begin
                state_next = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                state_next = sts.rem ? S_SHIFT : S_FINISH;
            end
            S_SHIFT:
            begin
                if (!sts.shift_busy)
                begin
                    state_next = sts.store ? S_STORE : S_FINISH;
                end
            end
            S_STORE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready       = 1'b0;
        cmd             = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            S_DECODE:
            begin
                cmd.plan = 1'b1;
            end
            S_TARGET:
            begin
                cmd.read_target = 1'b1;
            end
            S_CAPTURE:
            begin
                cmd.capture = 1'b1;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/cdq_datapath.sv
// Datapath of the circular deque: ring memory, head and count, shift sequencing and result register.
module cdq_datapath #(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cdq_pkg::cmd_t                        cmd,
    output cdq_pkg::sts_t                        sts,
    input  logic [cdq_pkg::OP_W-1:0]             operation,
    input  logic [cdq_pkg::RANK_W-1:0]           rank,
    input  logic signed [cdq_pkg::VALUE_W-1:0]   value,
    input  logic                                 rsp_ready,
    output logic                                 rsp_valid,
    output logic signed [cdq_pkg::VALUE_W-1:0]   result_value,
    output logic [cdq_pkg::STATUS_W-1:0]         status,
    output logic [cdq_pkg::COUNT_W-1:0]          element_count
);
    import cdq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > RANK_W) ? CW : RANK_W) + 1;
    localparam int LW = $clog2(CAPACITY / 2 + 1);

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        addr_inc = (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        addr_dec = (a == '0) ? AW'(CAPACITY - 1) : a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + (AW+1)'(off);
        if (s >= (AW+1)'(CAPACITY))
        begin
            s = s - (AW+1)'(CAPACITY);
        end
        addr_add = s[AW-1:0];
    endfunction

    logic [WORD_WIDTH-1:0] mem [CAPACITY];

    logic [OP_W-1:0]       op_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic [WORD_WIDTH-1:0] res_reg;
    logic [AW-1:0]         head_reg;
    logic [CW-1:0]         count_reg;
    status_t               status_reg;
    logic                  is_ins_reg;
    logic                  is_rem_reg;
    logic                  up_reg;
    logic [AW-1:0]         ptr_reg;
    logic [LW-1:0]         left_reg;
    logic                  pend_reg;
    logic [AW-1:0]         pend_addr_reg;
    logic [AW-1:0]         store_addr_reg;
    logic [AW-1:0]         target_addr_reg;
    logic [AW-1:0]         new_head_reg;
    logic [CW-1:0]         new_count_reg;
    logic                  rsp_valid_reg;
    logic [VALUE_W-1:0]    rsp_value_reg;
    status_t               rsp_status_reg;
    logic [COUNT_W-1:0]    rsp_count_reg;

    logic [63:0]           value_ext;
    logic [63:0]           res_ext;
    logic [EW-1:0]         rank_e;
    logic [EW-1:0]         cnt_e;
    logic                  full;
    logic                  empty;
    status_t               pl_status;
    logic                  pl_ins;
    logic                  pl_rem;
    logic                  pl_read;
    logic [CW-1:0]         pl_rank;
    logic [CW:0]           pl_r2;
    logic                  pl_back;
    logic [AW-1:0]         slot_r;
    logic [AW-1:0]         slot_rm1;
    logic [AW-1:0]         slot_rp1;
    logic [AW-1:0]         slot_last;
    logic                  pl_up;
    logic [AW-1:0]         pl_start;
    logic [CW-1:0]         pl_moves;
    logic [AW-1:0]         pl_store_addr;
    logic [AW-1:0]         pl_new_head;
    logic [CW-1:0]         pl_new_count;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    assign value_ext = {32'b0, value};
    assign res_ext   = 64'(res_reg);
    assign rank_e    = EW'(rank_reg);
    assign cnt_e     = EW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        pl_status = ST_OK;
        pl_ins    = 1'b0;
        pl_rem    = 1'b0;
        pl_read   = 1'b0;
        pl_rank   = '0;
        case (op_reg)
            OP_INSERT_AT:
            begin
                if (full)
                begin
                    pl_status = ST_FULL;
                end
                else if (rank_e > cnt_e)
                begin
                    pl_status = ST_RANK;
                end
                else
                begin
                    pl_ins  = 1'b1;
                    pl_rank = rank_e[CW-1:0];
                end
            end
            OP_REMOVE_AT:
            begin
                if (empty)
                begin
                    pl_status = ST_EMPTY;
                end
                else if (rank_e >= cnt_e)
                begin
                    pl_status = ST_RANK;
                end
                else
                begin
                    pl_rem  = 1'b1;
                    pl_rank = rank_e[CW-1:0];
                end
            end
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    pl_status = ST_FULL;
                end
                else
                begin
                    pl_ins = 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    pl_status = ST_FULL;
                end
                else
                begin
                    pl_ins  = 1'b1;
                    pl_rank = count_reg;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    pl_status = ST_EMPTY;
                end
                else
                begin
                    pl_rem = 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    pl_status = ST_EMPTY;
                end
                else
                begin
                    pl_rem  = 1'b1;
                    pl_rank = count_reg - 1'b1;
                end
            end
            OP_READ_AT:
            begin
                if (rank_e >= cnt_e)
                begin
                    pl_status = ST_RANK;
                end
                else
                begin
                    pl_read = 1'b1;
                    pl_rank = rank_e[CW-1:0];
                end
            end
            default:
            begin
                pl_status = ST_OK;
            end
        endcase
    end

    // The back side is shifted when twice the rank reaches the count.
    always_comb
    begin
        pl_r2         = {pl_rank, 1'b0};
        pl_back       = (pl_r2 >= {1'b0, count_reg});
        slot_r        = addr_add(head_reg, pl_rank);
        slot_rm1      = addr_dec(slot_r);
        slot_rp1      = addr_inc(slot_r);
        slot_last     = addr_dec(addr_add(head_reg, count_reg));
        pl_up         = 1'b0;
        pl_start      = slot_r;
        pl_moves      = '0;
        pl_store_addr = slot_r;
        pl_new_head   = head_reg;
        pl_new_count  = count_reg;
        if (pl_ins)
        begin
            pl_new_count = count_reg + 1'b1;
            if (pl_back)
            begin
                pl_start = slot_last;
                pl_moves = count_reg - pl_rank;
            end
            else
            begin
                pl_up         = 1'b1;
                pl_start      = head_reg;
                pl_moves      = pl_rank;
                pl_store_addr = slot_rm1;
                pl_new_head   = addr_dec(head_reg);
            end
        end
        else if (pl_rem)
        begin
            pl_new_count = count_reg - 1'b1;
            if (!pl_back)
            begin
                pl_start    = slot_rm1;
                pl_moves    = pl_rank;
                pl_new_head = addr_inc(head_reg);
            end
            else
            begin
                pl_up    = 1'b1;
                pl_start = slot_rp1;
                pl_moves = count_reg - pl_rank - 1'b1;
            end
            if (pl_new_count == '0)
            begin
                pl_new_head = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= operation;
            rank_reg <= rank;
            word_reg <= value_ext[WORD_WIDTH-1:0];
        end
        if (cmd.plan)
        begin
            status_reg      <= pl_status;
            is_ins_reg      <= pl_ins;
            is_rem_reg      <= pl_rem;
            up_reg          <= pl_up;
            store_addr_reg  <= pl_store_addr;
            target_addr_reg <= slot_r;
            new_head_reg    <= pl_new_head;
            new_count_reg   <= pl_new_count;
            res_reg         <= '0;
        end
        else if (cmd.capture)
        begin
            res_reg <= rd_data_reg;
        end
        if (cmd.plan)
        begin
            ptr_reg <= pl_start;
        end
        else if (cmd.shift && (left_reg != '0))
        begin
            ptr_reg       <= up_reg ? addr_inc(ptr_reg) : addr_dec(ptr_reg);
            pend_addr_reg <= up_reg ? addr_dec(ptr_reg) : addr_inc(ptr_reg);
        end
        if (cmd.finish)
        begin
            rsp_value_reg  <= res_ext[VALUE_W-1:0];
            rsp_status_reg <= status_reg;
            rsp_count_reg  <= COUNT_W'(new_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.plan)
            begin
                left_reg <= LW'(pl_moves);
                pend_reg <= 1'b0;
            end
            else if (cmd.shift)
            begin
                if (left_reg != '0)
                begin
                    left_reg <= left_reg - 1'b1;
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                head_reg      <= new_head_reg;
                count_reg     <= new_count_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // One read and one write per cycle: a shift reads the next source while the
    // previous word lands one place over.
    assign rd_en   = cmd.read_target || (cmd.shift && (left_reg != '0));
    assign rd_addr = cmd.read_target ? target_addr_reg : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.shift && pend_reg)
        begin
            mem[pend_addr_reg] <= rd_data_reg;
        end
        else if (cmd.store)
        begin
            mem[store_addr_reg] <= word_reg;
        end
    end

    assign sts.plan_target = pl_rem || pl_read;
    assign sts.plan_store  = pl_ins;
    assign sts.rem         = is_rem_reg;
    assign sts.store       = is_ins_reg;
    assign sts.shift_busy  = (left_reg != '0);
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    assign rsp_valid     = rsp_valid_reg;
    assign result_value  = rsp_value_reg;
    assign status        = rsp_status_reg;
    assign element_count = rsp_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("stored count exceeds the capacity");

    a_head_home: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0))
        else $error("head not at zero while the deque is empty");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= LW'(CAPACITY / 2))
        else $error("shift length exceeds half the capacity");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && (status_reg != ST_OK)) |=> (count_reg == $past(count_reg)))
        else $error("failed request changed the stored count");

endmodule
